### src/opr_pkg.sv
package opr_pkg;

    localparam int MaxTerms    = 256;
    localparam int TermIdxW    = 8;
    localparam int MaxExponent = 7;
    localparam int FracBits    = 24;
    localparam int ExpW        = 3;
    localparam int NumVars     = 5;
    localparam int NumCoefs    = 4;
    localparam int QueueDepth  = 2;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_EVENT = 1'b1;

    typedef struct packed {
        logic                    kind;
        logic [TermIdxW-1:0]     index;
        logic [14:0]             exps;
        logic [NumCoefs*32-1:0]  coefs;
        logic [NumVars*32-1:0]   vals;
    } opr_req_t;

    // round half up, clamp to 32 bits
    function automatic logic signed [31:0] fx_round_clamp(input logic signed [63:0] p);
        logic signed [63:0] r;
        r = (p + (64'sd1 <<< (FracBits - 1))) >>> FracBits;
        if (r > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
        if (r < -64'sh8000_0000) return 32'sh8000_0000;
        return r[31:0];
    endfunction

    function automatic logic signed [63:0] fx_round(input logic signed [63:0] p);
        return (p + (64'sd1 <<< (FracBits - 1))) >>> FracBits;
    endfunction

endpackage

### src/opr_ram.sv
module opr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### src/opr_front.sv
module opr_front import opr_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  opr_req_t in_req,
    output logic     q_valid,
    input  logic     q_ready,
    output opr_req_t q_req
);
    localparam int PtrW = $clog2(QueueDepth);

    opr_req_t           buf_reg [QueueDepth];
    logic [PtrW-1:0]    wr_reg, rd_reg;
    logic [PtrW:0]      cnt_reg;
    logic               push, pop;

    assign in_ready = (cnt_reg != (PtrW+1)'(QueueDepth));
    assign q_valid  = (cnt_reg != '0);
    assign q_req    = buf_reg[rd_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_reg] <= in_req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push) wr_reg <= wr_reg + 1'b1;
            if (pop)  rd_reg <= rd_reg + 1'b1;
            cnt_reg <= cnt_reg + (PtrW+1)'(push) - (PtrW+1)'(pop);
        end
    end
endmodule

### src/opr_back.sv
module opr_back import opr_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic [8:0]   term_count,
    input  logic         q_valid,
    output logic         q_ready,
    input  opr_req_t     q_req,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [127:0] out_sums,
    output logic         out_sat
);
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_FETCH = 7'b0000010,
        S_WAIT  = 7'b0000100,
        S_MONO  = 7'b0001000,
        S_MAC   = 7'b0010000,
        S_FINAL = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t                    state_reg, state_next;
    logic [TermIdxW:0]         term_reg;
    logic [TermIdxW:0]         n_terms;
    logic [2:0]                var_reg;
    logic [ExpW-1:0]           rep_reg;
    logic [1:0]                k_reg;
    logic signed [31:0]        mono_reg;
    logic signed [63:0]        prod_reg;
    logic                      prod_v_reg;
    logic signed [63:0]        acc_reg [NumCoefs];
    logic                      sat_reg;
    logic [NumVars*32-1:0]     vals_reg;
    logic [14:0]               exp_rd;
    logic [31:0]               coef_rd [NumCoefs];
    logic [ExpW-1:0]           e_cur;
    logic signed [31:0]        v_cur;
    logic                      ld;

    assign n_terms = (term_count > 9'(MaxTerms)) ? (TermIdxW+1)'(MaxTerms)
                                                 : term_count[TermIdxW:0];
    assign ld      = q_valid && (state_reg == S_IDLE) && (q_req.kind == REQ_LOAD);

    opr_ram #(.WIDTH(15), .DEPTH(MaxTerms)) u_exp (
        .clk(clk), .we(ld), .waddr(q_req.index), .wdata(q_req.exps),
        .raddr(term_reg[TermIdxW-1:0]), .rdata(exp_rd)
    );

    for (genvar g = 0; g < NumCoefs; g++)
    begin : g_coef
        opr_ram #(.WIDTH(32), .DEPTH(MaxTerms)) u_coef (
            .clk(clk), .we(ld), .waddr(q_req.index), .wdata(q_req.coefs[g*32 +: 32]),
            .raddr(term_reg[TermIdxW-1:0]), .rdata(coef_rd[g])
        );
    end

    always_comb
    begin
        e_cur = exp_rd[var_reg*ExpW +: ExpW];
        if (e_cur > ExpW'(MaxExponent)) e_cur = ExpW'(MaxExponent);
        v_cur = vals_reg[var_reg*32 +: 32];
    end

    assign q_ready   = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (q_valid && q_req.kind == REQ_EVENT)
                         state_next = (n_terms == '0) ? S_FINAL : S_FETCH;
            S_FETCH: state_next = S_WAIT;
            S_WAIT:  state_next = S_MONO;
            S_MONO:  if (var_reg == 3'(NumVars) && !prod_v_reg) state_next = S_MAC;
            S_MAC:   if (k_reg == 2'd3 && prod_v_reg)
                         state_next = (term_reg + 1'b1 == n_terms) ? S_FINAL : S_FETCH;
            S_FINAL: state_next = S_OUT;
            S_OUT:   if (out_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            term_reg   <= '0;
            prod_v_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                S_IDLE:
                begin
                    term_reg   <= '0;
                    prod_v_reg <= 1'b0;
                end
                S_MAC:
                begin
                    prod_v_reg <= !prod_v_reg;
                    if (k_reg == 2'd3 && prod_v_reg) term_reg <= term_reg + 1'b1;
                end
                S_MONO:  prod_v_reg <= (var_reg != 3'(NumVars)) && (rep_reg != e_cur)
                                       && !prod_v_reg;
                default: prod_v_reg <= 1'b0;
            endcase
        end
    end

    // products are registered and rounded before the next multiply is issued
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                vals_reg <= q_req.vals;
                sat_reg  <= 1'b0;
                for (int i = 0; i < NumCoefs; i++) acc_reg[i] <= '0;
            end
            S_FETCH:
            begin
                var_reg  <= '0;
                rep_reg  <= '0;
                k_reg    <= '0;
                mono_reg <= 32'sd1 <<< FracBits;
            end
            S_MONO:
            begin
                if (prod_v_reg)
                begin
                    mono_reg <= fx_round_clamp(prod_reg);
                    rep_reg  <= rep_reg + 1'b1;
                end
                else if (var_reg != 3'(NumVars))
                begin
                    if (rep_reg == e_cur)
                    begin
                        var_reg <= var_reg + 1'b1;
                        rep_reg <= '0;
                    end
                    else
                    begin
                        prod_reg <= 64'(mono_reg) * 64'(v_cur);
                    end
                end
            end
            S_MAC:
            begin
                if (!prod_v_reg)
                begin
                    prod_reg <= 64'(mono_reg) * 64'(signed'(coef_rd[k_reg]));
                end
                else
                begin
                    logic signed [63:0] b, s;
                    b = fx_round(prod_reg);
                    s = acc_reg[k_reg] + b;
                    if (b > 0 && acc_reg[k_reg] > 0 && s < 0)
                    begin
                        acc_reg[k_reg] <= 64'sh7FFF_FFFF_FFFF_FFFF;
                        sat_reg <= 1'b1;
                    end
                    else if (b < 0 && acc_reg[k_reg] < 0 && s >= 0)
                    begin
                        acc_reg[k_reg] <= 64'sh8000_0000_0000_0000;
                        sat_reg <= 1'b1;
                    end
                    else
                    begin
                        acc_reg[k_reg] <= s;
                    end
                    k_reg <= k_reg + 1'b1;
                end
            end
            S_FINAL:
            begin
                for (int i = 0; i < NumCoefs; i++)
                begin
                    if (acc_reg[i] > 64'sh7FFF_FFFF)
                    begin
                        out_sums[i*32 +: 32] <= 32'h7FFF_FFFF;
                        sat_reg <= 1'b1;
                    end
                    else if (acc_reg[i] < -64'sh8000_0000)
                    begin
                        out_sums[i*32 +: 32] <= 32'h8000_0000;
                        sat_reg <= 1'b1;
                    end
                    else
                    begin
                        out_sums[i*32 +: 32] <= acc_reg[i][31:0];
                    end
                end
            end
            default: ;
        endcase
    end

    assign out_sat = sat_reg;
endmodule

### src/optics_polynomial_reconstruction.sv
// Optics polynomial evaluator. A load request (tuser 0) writes one term of
// exponents and four coefficients; an event request (tuser 1) sums
// coefficient times monomial over the first term_count terms (at most 256)
// and returns one result. Per term the exponents and coefficients are fetched,
// each monomial factor is multiplied in and rounded in turn, and then the four
// coefficient products are formed and accumulated; all products share one
// product register. Loads are written while idle. A two-entry request queue
// separates the input from the evaluator.
module optics_polynomial_reconstruction import opr_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [8:0]   cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // term_index, term_exponents, coef_xptar, coef_yptar, coef_ytar, coef_delta,
    // focal_x, focal_y, focal_xslope, focal_yslope, target_x; padded to 312
    input  logic [311:0] s_tdata,
    // req_type
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // recon_xptar, recon_yptar, recon_ytar, recon_delta, saturated; padded to 136
    output logic [135:0] m_tdata
);
    logic [8:0]   term_count_reg;
    opr_req_t     in_req, q_req;
    logic         q_valid, q_ready, sat;
    logic [127:0] sums;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) term_count_reg <= '0;
        else if (cfg_we) term_count_reg <= cfg_wdata;
    end

    assign in_req.kind  = s_tuser;
    assign in_req.index = s_tdata[7:0];
    assign in_req.exps  = s_tdata[22:8];
    assign in_req.coefs = s_tdata[150:23];
    assign in_req.vals  = s_tdata[310:151];

    opr_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(s_tvalid), .in_ready(s_tready),
        .in_req(in_req), .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req)
    );

    opr_back u_back (
        .clk(clk), .rst_n(rst_n), .term_count(term_count_reg),
        .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_sums(sums), .out_sat(sat)
    );

    assign m_tdata = {7'd0, sat, sums};
endmodule
